FILE: rtl/core/sobol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol generator package
// Shared types, constants and action codes.
// ----------------------------------------------------------------------------
package sobol_pkg;

    localparam int MAX_DIMS  = 16;
    localparam int WORD_BITS = 32;
    localparam int DIM_W     = $clog2(MAX_DIMS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int TAB_W     = DIM_W + BIT_W;
    localparam int QDEPTH    = 2;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_EXTEND  = 3'd1,
        ACT_NEXT    = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_SHIFT   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CFG_BITS  = 2'd0,
        CFG_DIMS  = 2'd1,
        CFG_SHIFT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  dim_index;
        logic [5:0]  bit_index;
        logic [31:0] word;
        logic [4:0]  degree;
        logic [29:0] poly_bits;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  dim_out;
        logic [31:0] coordinate;
        logic        last;
        logic        status;
    } out_item_t;

    // classified command passed from front to back
    typedef struct packed {
        action_t     action;
        logic [DIM_W-1:0] dim;
        logic [BIT_W-1:0] bpos;
        logic [31:0] word;
        logic [4:0]  degree;
        logic [29:0] poly_bits;
    } cmd_t;

endpackage

FILE: rtl/core/sobol_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol front end
// Accepts commands, drops invalid ones, queues the rest for the back end.
// ----------------------------------------------------------------------------
module sobol_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sobol_pkg::in_item_t  item,
    output logic                 busy,
    output logic                 q_valid,
    output sobol_pkg::cmd_t      q_cmd,
    input  logic                 q_pop
);

    sobol_pkg::cmd_t  q_mem [sobol_pkg::QDEPTH];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             keep;
    logic             push;
    sobol_pkg::cmd_t  cmd;

    always_comb
    begin
        cmd.action    = sobol_pkg::action_t'(item.action);
        cmd.dim       = item.dim_index;
        cmd.bpos      = 5'(item.bit_index - 6'd1);
        cmd.word      = item.word;
        cmd.degree    = item.degree;
        cmd.poly_bits = item.poly_bits;
        unique case (item.action)
            sobol_pkg::ACT_WRITE:   keep = (item.bit_index != 6'd0) && (item.bit_index <= 6'd32);
            sobol_pkg::ACT_EXTEND:  keep = (item.degree != 5'd0);
            sobol_pkg::ACT_NEXT,
            sobol_pkg::ACT_RESTART,
            sobol_pkg::ACT_SHIFT:   keep = 1'b1;
            default:                keep = 1'b0;
        endcase
    end

    assign busy    = (cnt_reg == 2'(sobol_pkg::QDEPTH));
    assign push    = start && !busy && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, q_pop});
        end
    end

endmodule

FILE: rtl/core/sobol_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol back end
// Direction memory, extend sequencer, point update and coordinate emission.
// ----------------------------------------------------------------------------
module sobol_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sobol_pkg::cmd_t      q_cmd,
    output logic                 q_pop,
    input  logic [5:0]           bits_in_use,
    input  logic [4:0]           dims_in_use,
    input  logic                 apply_shift,
    output logic                 result_valid,
    output sobol_pkg::out_item_t result
);

    localparam int DW = sobol_pkg::DIM_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXT_RD, ST_EXT_WAIT, ST_EXT_ACC, ST_NXT_RD, ST_NXT_UPD, ST_EMIT
    } state_t;

    state_t            state_reg;
    sobol_pkg::cmd_t   cmd_reg;
    logic [31:0]       dir_mem [sobol_pkg::MAX_DIMS * sobol_pkg::WORD_BITS];
    logic [31:0]       rd_reg;
    logic [sobol_pkg::TAB_W-1:0] rd_addr;
    logic              mem_we;
    logic [sobol_pkg::TAB_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [31:0]       shift_reg [sobol_pkg::MAX_DIMS];
    logic [31:0]       pstate_reg [sobol_pkg::MAX_DIMS];
    logic [32:0]       pcnt_reg;
    logic [5:0]        col_reg;
    logic [5:0]        i_reg;
    logic [5:0]        k_reg;
    logic [31:0]       acc_reg;
    logic [DW-1:0]     d_reg;
    logic              exh_reg;
    logic [5:0]        eff_l;
    logic [4:0]        eff_d;
    logic              exhausted;
    logic [5:0]        tz;
    logic [5:0]        s6;
    logic              abit;
    logic [31:0]       x;

    always_comb
    begin
        eff_l = (bits_in_use == 6'd0) ? 6'd1 : ((bits_in_use > 6'd32) ? 6'd32 : bits_in_use);
        eff_d = (dims_in_use == 5'd0) ? 5'd1 : ((dims_in_use > 5'd16) ? 5'd16 : dims_in_use);
        exhausted = (col_reg > eff_l) || ((pcnt_reg >> eff_l) != 33'd0);
        tz = 6'd1;
        for (int j = 0; j < 33; j++)
        begin
            if (pcnt_reg[j] && (tz == 6'(j + 1)))
            begin
                tz = 6'(j + 2);
            end
        end
        s6 = {1'b0, cmd_reg.degree};
        abit = cmd_reg.poly_bits[5'(s6 - 6'd1 - k_reg)];
        x = pstate_reg[d_reg] + (apply_shift ? shift_reg[d_reg] : 32'd0);
    end

    // read address per state: extend reads V[i-s] then V[i-k]; next reads V[d][col]
    always_comb
    begin
        rd_addr = {d_reg, 5'(col_reg - 6'd1)};
        if (state_reg == ST_EXT_RD)
        begin
            rd_addr = {cmd_reg.dim, 5'(i_reg - s6 - 6'd1)};
        end
        else if (state_reg == ST_EXT_ACC || state_reg == ST_EXT_WAIT)
        begin
            rd_addr = {cmd_reg.dim, 5'(i_reg - k_reg - 6'd1)};
        end
        mem_we  = 1'b0;
        wr_addr = {cmd_reg.dim, cmd_reg.bpos};
        wr_data = cmd_reg.word;
        if (state_reg == ST_IDLE && q_valid && q_cmd.action == sobol_pkg::ACT_WRITE)
        begin
            mem_we  = 1'b1;
            wr_addr = {q_cmd.dim, q_cmd.bpos};
            wr_data = q_cmd.word;
        end
        else if (state_reg == ST_EXT_ACC && k_reg == 6'd0)
        begin
            mem_we  = 1'b1;
            wr_addr = {cmd_reg.dim, 5'(i_reg - 6'd1)};
            wr_data = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dir_mem[wr_addr] <= wr_data;
        end
        rd_reg <= dir_mem[rd_addr];
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pcnt_reg     <= 33'd1;
            col_reg      <= 6'd1;
            result_valid <= 1'b0;
            d_reg        <= '0;
            for (int j = 0; j < sobol_pkg::MAX_DIMS; j++)
            begin
                shift_reg[j]  <= 32'd0;
                pstate_reg[j] <= 32'd0;
            end
        end
        else
        begin
            result_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        d_reg   <= '0;
                        unique case (q_cmd.action)
                            sobol_pkg::ACT_EXTEND:
                            begin
                                i_reg <= 6'({1'b0, q_cmd.degree} + 6'd1);
                                if ({1'b0, q_cmd.degree} < eff_l)
                                begin
                                    state_reg <= ST_EXT_RD;
                                end
                            end
                            sobol_pkg::ACT_NEXT:
                            begin
                                exh_reg <= exhausted;
                                state_reg <= exhausted ? ST_EMIT : ST_NXT_RD;
                            end
                            sobol_pkg::ACT_RESTART:
                            begin
                                pcnt_reg <= 33'd1;
                                col_reg  <= 6'd1;
                                for (int j = 0; j < sobol_pkg::MAX_DIMS; j++)
                                begin
                                    pstate_reg[j] <= 32'd0;
                                end
                            end
                            sobol_pkg::ACT_SHIFT:
                            begin
                                shift_reg[q_cmd.dim] <= q_cmd.word;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_EXT_RD:
                begin
                    k_reg     <= 6'(s6 - 6'd1);
                    state_reg <= ST_EXT_WAIT;
                end
                ST_EXT_WAIT:
                begin
                    // first pass of a bit seeds the sum with V[i-s]
                    if (k_reg == 6'(s6 - 6'd1))
                    begin
                        acc_reg <= rd_reg ^ (rd_reg >> s6);
                    end
                    state_reg <= ST_EXT_ACC;
                end
                ST_EXT_ACC:
                begin
                    if (k_reg == 6'd0)
                    begin
                        i_reg <= 6'(i_reg + 6'd1);
                        state_reg <= (i_reg == eff_l) ? ST_IDLE : ST_EXT_RD;
                    end
                    else
                    begin
                        if (abit)
                        begin
                            acc_reg <= acc_reg ^ rd_reg;
                        end
                        k_reg     <= 6'(k_reg - 6'd1);
                        state_reg <= ST_EXT_WAIT;
                    end
                end
                ST_NXT_RD:
                begin
                    state_reg <= ST_NXT_UPD;
                end
                ST_NXT_UPD:
                begin
                    pstate_reg[d_reg] <= pstate_reg[d_reg] ^ rd_reg;
                    d_reg <= DW'(d_reg + 1'b1);
                    if (d_reg == DW'(sobol_pkg::MAX_DIMS - 1))
                    begin
                        col_reg   <= tz;
                        pcnt_reg  <= 33'(pcnt_reg + 33'd1);
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_NXT_RD;
                    end
                end
                ST_EMIT:
                begin
                    result_valid      <= 1'b1;
                    result.dim_out    <= d_reg;
                    result.coordinate <= x;
                    result.last       <= ({1'b0, d_reg} == 5'(eff_d - 5'd1));
                    result.status     <= exh_reg;
                    d_reg <= DW'(d_reg + 1'b1);
                    if ({1'b0, d_reg} == 5'(eff_d - 5'd1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sobol_sequence_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol sequence generator
// Gray-code Sobol points, one 0.32 coordinate per dimension.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. A two-entry
//   queue decouples acceptance from execution, so busy rises only when full.
//   Write, shift and restart are executed in the back end's idle state.
//   Extend computes each generated bit in turn, reading earlier direction
//   words through the single direction memory read port. A next action
//   reads the direction memory once per dimension for the state update
//   (skipped when exhausted) and then gives one result beat per dimension
//   in use, on result with result_valid high for one cycle each; last marks
//   the final beat. The receiver cannot stall.
//   Config writes (cfg_valid/cfg_ready) are taken at any time; cfg_ready is
//   always high. Reset sets bits 32, dims 16, shift off, clears state and
//   shift values; the direction memory is undefined until written.
// ----------------------------------------------------------------------------
module sobol_sequence_generator
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sobol_pkg::in_item_t  item,
    output logic                 busy,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 result_valid,
    output sobol_pkg::out_item_t result
);

    logic            q_valid;
    logic            q_pop;
    sobol_pkg::cmd_t q_cmd;
    logic [5:0]      bits_reg;
    logic [4:0]      dims_reg;
    logic            shift_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg     <= 6'd32;
            dims_reg     <= 5'd16;
            shift_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sobol_pkg::CFG_BITS:  bits_reg     <= cfg_data[5:0];
                sobol_pkg::CFG_DIMS:  dims_reg     <= cfg_data[4:0];
                sobol_pkg::CFG_SHIFT: shift_en_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    sobol_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    sobol_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .bits_in_use  (bits_reg),
        .dims_in_use  (dims_reg),
        .apply_shift  (shift_en_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: rtl/core/sobol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol port checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module sobol_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input sobol_pkg::out_item_t result
);

    a_dim_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> (result_valid &&
        result.dim_out == 4'($past(result.dim_out) + 4'd1)))
        else $error("dimension sequence broken");

    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> $stable(result.status))
        else $error("status changed within a point");

    a_first_dim: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result_valid)) |-> (result.dim_out == 4'd0))
        else $error("point not starting at dimension zero");

endmodule

bind sobol_sequence_generator sobol_checker u_sobol_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);
